### design/lpcp_pkg.sv
package lpcp_pkg;

   localparam int IN_WORDS    = 64;
   localparam int IDX_W       = (IN_WORDS > 1) ? $clog2(IN_WORDS) : 1;
   localparam int RD_W        = 12;
   localparam int RAM_AW      = IDX_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [RD_W-1:0]  OWPL_RESET   = 12'd64;
   localparam logic [RD_W-1:0]  IN_WORDS_RD  = RD_W'(IN_WORDS);
   localparam logic [IDX_W-1:0] LAST_WR_IDX  = IDX_W'(IN_WORDS - 1);
   localparam logic             CSR_IDX_OWPL = 1'b0;

   // Per-beat issue record handed from the front to the back.
   typedef struct packed {
      logic       start;
      logic       strb;
      logic [3:0] id;
      logic [3:0] dest;
      logic       zero;
      logic       fwd_hi;
      logic       fwd_lo;
      logic [7:0] byte_val;
   } issue_type;

   typedef struct packed {
      logic [15:0] word;
      logic        strb;
      logic        start;
      logic [3:0]  id;
      logic [3:0]  dest;
   } result_type;

endpackage

### design/lpcp_ram.sv
module lpcp_ram #(
   parameter int ADDR_W = 7,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/lpcp_front.sv
module lpcp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    in_byte,
   input  logic                          in_strb,
   input  logic [3:0]                    in_id,
   input  logic [3:0]                    in_dest,
   input  logic [lpcp_pkg::RD_W-1:0]     owpl,
   output logic                          ram_we_hi,
   output logic                          ram_we_lo,
   output logic [lpcp_pkg::RAM_AW-1:0]   ram_waddr,
   output logic [7:0]                    ram_wdata,
   output logic [lpcp_pkg::RAM_AW-1:0]   ram_raddr,
   output logic                          emit,
   output lpcp_pkg::issue_type           issue
);

   logic [lpcp_pkg::IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic                       phase_ff, phase_in;
   logic                       wr_b_ff, wr_b_in;
   logic                       a_full_ff, a_full_in;
   logic                       b_full_ff, b_full_in;
   logic [lpcp_pkg::RD_W-1:0]  ridx_a_ff, ridx_a_in;
   logic [lpcp_pkg::RD_W-1:0]  ridx_b_ff, ridx_b_in;
   logic                       start_ff, start_in;

   logic [lpcp_pkg::RD_W-1:0]  rd_idx;
   logic                       in_range;
   logic                       fwd;
   logic                       wrap;

   assign ram_waddr = {wr_b_ff, wr_idx_ff};
   assign ram_wdata = in_byte;
   assign ram_we_hi = accept && !phase_ff;
   assign ram_we_lo = accept && phase_ff;

   // Store B wins when both are full.
   assign rd_idx    = b_full_ff ? ridx_b_ff : ridx_a_ff;
   assign in_range  = rd_idx < lpcp_pkg::IN_WORDS_RD;
   assign ram_raddr = {b_full_ff, rd_idx[lpcp_pkg::IDX_W-1:0]};
   assign fwd       = in_range && (wr_b_ff == b_full_ff)
                      && (wr_idx_ff == rd_idx[lpcp_pkg::IDX_W-1:0]);
   assign emit      = a_full_ff || b_full_ff;
   assign wrap      = wr_idx_ff == lpcp_pkg::LAST_WR_IDX;

   always_comb begin
      issue.start    = start_ff;
      issue.strb     = in_strb;
      issue.id       = in_id;
      issue.dest     = in_dest;
      issue.zero     = !in_range;
      issue.fwd_hi   = fwd && !phase_ff;
      issue.fwd_lo   = fwd && phase_ff;
      issue.byte_val = in_byte;
   end

   always_comb begin
      wr_idx_in = wr_idx_ff;
      phase_in  = !phase_ff;
      wr_b_in   = wr_b_ff;
      a_full_in = a_full_ff;
      b_full_in = b_full_ff;
      ridx_a_in = a_full_ff ? ridx_a_ff + 1'b1 : ridx_a_ff;
      ridx_b_in = b_full_ff ? ridx_b_ff + 1'b1 : ridx_b_ff;
      start_in  = emit ? 1'b0 : start_ff;
      if (phase_ff) begin
         if (wrap) begin
            wr_idx_in = '0;
            wr_b_in   = !wr_b_ff;
            start_in  = 1'b1;
            if (wr_b_ff) begin
               b_full_in = 1'b1;
            end else begin
               a_full_in = 1'b1;
            end
         end else begin
            wr_idx_in = wr_idx_ff + 1'b1;
         end
      end
      if (ridx_a_in == owpl) begin
         a_full_in = 1'b0;
         ridx_a_in = '0;
      end
      if (ridx_b_in == owpl) begin
         b_full_in = 1'b0;
         ridx_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         phase_ff  <= 1'b0;
         wr_b_ff   <= 1'b0;
         a_full_ff <= 1'b0;
         b_full_ff <= 1'b0;
         ridx_a_ff <= '0;
         ridx_b_ff <= '0;
         start_ff  <= 1'b0;
      end else if (accept) begin
         wr_idx_ff <= wr_idx_in;
         phase_ff  <= phase_in;
         wr_b_ff   <= wr_b_in;
         a_full_ff <= a_full_in;
         b_full_ff <= b_full_in;
         ridx_a_ff <= ridx_a_in;
         ridx_b_ff <= ridx_b_in;
         start_ff  <= start_in;
      end
   end

endmodule

### design/lpcp_back.sv
module lpcp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                issue_valid,
   input  lpcp_pkg::issue_type issue,
   input  logic [7:0]          ram_rdata_hi,
   input  logic [7:0]          ram_rdata_lo,
   input  logic                rsp_stall,
   output logic                room,
   output logic                rsp_valid,
   output lpcp_pkg::result_type rsp
);

   logic                          s1_valid_ff;
   lpcp_pkg::issue_type           s1_ff;
   lpcp_pkg::result_type          merged;
   lpcp_pkg::result_type          q_ff [lpcp_pkg::QUEUE_DEPTH];
   logic [lpcp_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [lpcp_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [lpcp_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [lpcp_pkg::QCNT_W-1:0]   used;
   logic                          push;
   logic                          pop;

   // Merge the registered RAM read with the byte written in the same beat.
   always_comb begin
      merged.word[15:8] = s1_ff.fwd_hi ? s1_ff.byte_val : ram_rdata_hi;
      merged.word[7:0]  = s1_ff.fwd_lo ? s1_ff.byte_val : ram_rdata_lo;
      if (s1_ff.zero) begin
         merged.word = '0;
      end
      merged.strb  = s1_ff.strb;
      merged.start = s1_ff.start;
      merged.id    = s1_ff.id;
      merged.dest  = s1_ff.dest;
   end

   assign push      = s1_valid_ff;
   assign rsp_valid = cnt_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp       = q_ff[rd_ptr_ff];
   assign used      = cnt_ff + lpcp_pkg::QCNT_W'(s1_valid_ff);
   assign room      = used < lpcp_pkg::QCNT_W'(lpcp_pkg::QUEUE_DEPTH);
   assign cnt_in    = cnt_ff + lpcp_pkg::QCNT_W'(push) - lpcp_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (issue_valid) begin
         s1_ff <= issue;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= issue_valid;
         cnt_ff      <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

### design/line_pack_crop_pad.sv
// Ping-pong line buffer with byte-to-word packing and crop/pad on readout.
// Every req beat carries one pixel byte; byte pairs pack into 16-bit words
// (first byte high) and land in line store A or B, each IN_WORDS words deep,
// both held in one pair of byte-wide RAMs. When a store fills, it turns full,
// writing moves to the other store, and the next emitted rsp beat carries
// start. While a store is full, each req beat yields one rsp beat: stored
// words first, then zeros, until out_words_per_line words (CSR at byte
// address 0, reset 64) have gone out; store B is read when both are full.
// Throughput is one req beat per clock while req_stall is low. A word
// reaches rsp through the registered RAM read and then the result queue.
// The queue holds four beats; req_stall rises once queued plus in-flight
// beats reach four, and it never looks at rsp_stall in the same cycle. No
// clearing pass runs after reset; the block is ready at once.
module line_pack_crop_pad (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_in_strb,
   input  logic [3:0]                    req_in_id,
   input  logic [3:0]                    req_in_dest,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [15:0]                   rsp_out_word,
   output logic                          rsp_out_strb,
   output logic                          rsp_out_keep,
   output logic                          rsp_out_start,
   output logic [3:0]                    rsp_out_id,
   output logic [3:0]                    rsp_out_dest,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lpcp_pkg::CSR_AW-1:0]   paddr,
   input  logic [lpcp_pkg::CSR_DW-1:0]   pwdata,
   output logic [lpcp_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   logic [lpcp_pkg::RD_W-1:0]   owpl_ff, owpl_in;
   logic                        csr_wr;
   logic                        sel_owpl;

   logic                        accept;
   logic                        room;
   logic                        emit;
   logic                        issue_valid;
   lpcp_pkg::issue_type         issue;
   lpcp_pkg::result_type        rsp;

   logic                        ram_we_hi;
   logic                        ram_we_lo;
   logic [lpcp_pkg::RAM_AW-1:0] ram_waddr;
   logic [7:0]                  ram_wdata;
   logic [lpcp_pkg::RAM_AW-1:0] ram_raddr;
   logic [7:0]                  ram_rdata_hi;
   logic [7:0]                  ram_rdata_lo;

   // Register file: one register, words per output line.
   assign pready   = 1'b1;
   assign sel_owpl = paddr[2] == lpcp_pkg::CSR_IDX_OWPL;
   assign csr_wr   = psel && penable && pwrite && pready;
   assign owpl_in  = (csr_wr && sel_owpl) ? pwdata[lpcp_pkg::RD_W-1:0] : owpl_ff;
   assign prdata   = sel_owpl ? lpcp_pkg::CSR_DW'(owpl_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         owpl_ff <= lpcp_pkg::OWPL_RESET;
      end else begin
         owpl_ff <= owpl_in;
      end
   end

   // Take a beat whenever the back has room for everything in flight.
   assign req_stall   = !room;
   assign accept      = req_valid && !req_stall;
   assign issue_valid = accept && emit;

   lpcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_strb   (req_in_strb),
      .in_id     (req_in_id),
      .in_dest   (req_in_dest),
      .owpl      (owpl_ff),
      .ram_we_hi (ram_we_hi),
      .ram_we_lo (ram_we_lo),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .emit      (emit),
      .issue     (issue)
   );

   // High and low byte lanes of both line stores; the top address bit picks B.
   lpcp_ram #(
      .ADDR_W (lpcp_pkg::RAM_AW),
      .DATA_W (8)
   ) u_ram_hi (
      .clock (clock),
      .we    (ram_we_hi),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_hi)
   );

   lpcp_ram #(
      .ADDR_W (lpcp_pkg::RAM_AW),
      .DATA_W (8)
   ) u_ram_lo (
      .clock (clock),
      .we    (ram_we_lo),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_lo)
   );

   lpcp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .issue_valid  (issue_valid),
      .issue        (issue),
      .ram_rdata_hi (ram_rdata_hi),
      .ram_rdata_lo (ram_rdata_lo),
      .rsp_stall    (rsp_stall),
      .room         (room),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp)
   );

   assign rsp_out_word  = rsp.word;
   assign rsp_out_strb  = rsp.strb;
   assign rsp_out_keep  = 1'b1;
   assign rsp_out_start = rsp.start;
   assign rsp_out_id    = rsp.id;
   assign rsp_out_dest  = rsp.dest;

   // An emitting beat must show up at rsp once it has passed the s1 register and the result queue.
   a_emit_reaches_rsp : assert property (@(posedge clock) disable iff (reset)
      issue_valid |=> ##1 rsp_valid)
      else $error("emitted beat did not reach rsp");

   // A beat writes exactly one byte lane; an idle cycle writes none.
   a_one_lane : assert property (@(posedge clock) disable iff (reset)
      $onehot0({ram_we_hi, ram_we_lo}) && ((ram_we_hi || ram_we_lo) == accept))
      else $error("byte lane write mismatch");

   // After a stalled cycle without room, a beat is accepted only when the back has room.
   a_no_accept_when_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && !room) |=> (!accept || room))
      else $error("accept without room");

endmodule
